>>> hw/rtl/okl_pkg.sv
package okl_pkg;

    localparam int KEY_W = 16;
    localparam int ACT_W = 2;
    localparam int ST_W = 3;
    localparam int TDATA_W = 24;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_LIST   = 2'd1,
        ACT_REMOVE = 2'd2
    } okl_action_t;

    typedef enum logic [ST_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4,
        ST_LISTED    = 3'd5
    } okl_status_t;

    // per-cell control: shift from right neighbor, or load a new key
    typedef struct packed {
        logic             shift;
        logic             load;
        logic [KEY_W-1:0] load_key;
    } okl_cell_ctrl_t;

endpackage

>>> hw/rtl/okl_cell.sv
module okl_cell (
    input  logic                      aclk,
    input  okl_pkg::okl_cell_ctrl_t   ctrl,
    input  logic [okl_pkg::KEY_W-1:0] right_key,
    output logic [okl_pkg::KEY_W-1:0] key
);

    logic [okl_pkg::KEY_W-1:0] key_reg;
    logic [okl_pkg::KEY_W-1:0] key_next;

    // load wins over shift: the tail cell takes the rotated head
    always_comb begin
        key_next = key_reg;
        if (ctrl.load) begin
            key_next = ctrl.load_key;
        end else if (ctrl.shift) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

>>> hw/rtl/ordered_key_list_append_delete_unit.sv
// ordered key list: append at tail, remove first match, list all keys in order
//
// channels: s_ carries requests (action, key); m_ carries results (status,
// key_out, tlast on the final result of a request). both use tvalid/tready.
// storage is a chain of DEPTH cells; cell 0 is the head. list and remove run
// as a rotation: each cycle that the output register is free, the head leaves
// cell 0, every cell takes its right neighbor, and the head is written back at
// the current tail cell (or dropped on the first match of a remove), so order
// is kept with neighbor moves only. append, full and empty requests finish in
// the accepting cycle, with the result in the output register the cycle after;
// unused codes give no result. list of n keys: one result per cycle while the
// output register is free; remove on n keys: one result after n rotation steps.
// throughput: one request at a time; s_tready is high only when the control
// is idle and the output register is free or being drained this cycle.
// reset clears the key count (list empty), the control state and m_tvalid;
// cell contents are not reset. a stall on m_tready freezes the rotation, so
// no result is lost; the next request is taken only once a waiting result drains.
module ordered_key_list_append_delete_unit #(
    parameter int DEPTH = okl_pkg::DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [okl_pkg::TDATA_W-1:0] s_tdata,   // [1:0] action, [17:2] key
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [okl_pkg::TDATA_W-1:0] m_tdata,   // [2:0] status, [18:3] key_out
    output logic                        m_tlast
);

    localparam int KEY_W = okl_pkg::KEY_W;
    localparam int ST_W = okl_pkg::ST_W;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OUT_PAD = okl_pkg::TDATA_W - ST_W - KEY_W;
    localparam int ACT_LSB = 0;

    // one-hot control states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LIST   = 3'b010,
        S_REMOVE = 3'b100
    } okl_state_t;

    okl_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;    // keys held
    logic [CNT_W-1:0] remain_reg, remain_next;  // rotation steps left
    logic             found_reg, found_next;    // remove already dropped a key
    logic [KEY_W-1:0] req_key_reg, req_key_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    okl_pkg::okl_status_t m_status_reg, m_status_next;
    logic [KEY_W-1:0]     m_key_reg, m_key_next;
    logic                 m_last_reg, m_last_next;

    // request fields
    okl_pkg::okl_action_t s_action;
    logic [KEY_W-1:0]     s_key;
    logic                 s_acc;
    logic                 out_free;

    // cell chain
    logic [KEY_W-1:0]         cell_key [DEPTH];
    okl_pkg::okl_cell_ctrl_t  cell_ctrl [DEPTH];
    logic                     shift_all;
    logic                     load_any;
    logic [IDX_W-1:0]         load_idx;
    logic [KEY_W-1:0]         load_key;
    logic [KEY_W-1:0]         head_key;
    logic [CNT_W-1:0]         tail_sum;
    logic [IDX_W-1:0]         tail_idx;
    logic                     drop;

    assign s_action = okl_pkg::okl_action_t'(s_tdata[ACT_LSB +: okl_pkg::ACT_W]);
    assign s_key    = s_tdata[okl_pkg::ACT_W +: KEY_W];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;

    assign head_key = cell_key[0];
    assign tail_sum = count_reg - CNT_W'(1);
    assign tail_idx = tail_sum[IDX_W-1:0];
    assign drop     = !found_reg && (head_key == req_key_reg);

    // cells: each takes its right neighbor on a shift; the last one holds
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_ctrl[i].shift    = shift_all;
        assign cell_ctrl[i].load     = load_any && (load_idx == IDX_W'(i));
        assign cell_ctrl[i].load_key = load_key;

        okl_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .right_key ((i == DEPTH - 1) ? cell_key[i] : cell_key[(i + 1) % DEPTH]),
            .key       (cell_key[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        found_next    = found_reg;
        req_key_next  = req_key_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_key_next    = m_key_reg;
        m_last_next   = m_last_reg;
        shift_all     = 1'b0;
        load_any      = 1'b0;
        load_idx      = tail_idx;
        load_key      = head_key;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    case (s_action)
                        okl_pkg::ACT_APPEND: begin
                            m_valid_next = 1'b1;
                            m_key_next   = s_key;
                            m_last_next  = 1'b1;
                            if (count_reg == CNT_W'(DEPTH)) begin
                                m_status_next = okl_pkg::ST_FULL;
                            end else begin
                                load_any      = 1'b1;
                                load_idx      = count_reg[IDX_W-1:0];
                                load_key      = s_key;
                                count_next    = count_reg + CNT_W'(1);
                                m_status_next = okl_pkg::ST_APPENDED;
                            end
                        end
                        okl_pkg::ACT_LIST, okl_pkg::ACT_REMOVE: begin
                            req_key_next = s_key;
                            found_next   = 1'b0;
                            remain_next  = count_reg;
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = okl_pkg::ST_EMPTY;
                                m_key_next    = s_key;
                                m_last_next   = 1'b1;
                            end else if (s_action == okl_pkg::ACT_LIST) begin
                                state_next = S_LIST;
                            end else begin
                                state_next = S_REMOVE;
                            end
                        end
                        default: begin
                            // unused code: no result, no change
                        end
                    endcase
                end
            end

            S_LIST: begin
                if (out_free) begin
                    // rotate head to tail and emit it
                    shift_all     = 1'b1;
                    load_any      = 1'b1;
                    m_valid_next  = 1'b1;
                    m_status_next = okl_pkg::ST_LISTED;
                    m_key_next    = head_key;
                    m_last_next   = (remain_reg == CNT_W'(1));
                    remain_next   = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_REMOVE: begin
                if (out_free) begin
                    // rotate, dropping the first matching head
                    shift_all   = 1'b1;
                    remain_next = remain_reg - CNT_W'(1);
                    if (drop) begin
                        count_next = count_reg - CNT_W'(1);
                        found_next = 1'b1;
                    end else begin
                        load_any = 1'b1;
                    end
                    if (remain_reg == CNT_W'(1)) begin
                        state_next    = S_IDLE;
                        m_valid_next  = 1'b1;
                        m_status_next = (found_reg || drop) ? okl_pkg::ST_REMOVED
                                                            : okl_pkg::ST_NOT_FOUND;
                        m_key_next    = req_key_reg;
                        m_last_next   = 1'b1;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_key_reg  <= req_key_next;
        m_status_reg <= m_status_next;
        m_key_reg    <= m_key_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, m_key_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    // key count never exceeds the chain length
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("key count above depth");

    // a rotation always has steps left and never more than the keys held
    a_remain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST || state_reg == S_REMOVE) |->
            (remain_reg != '0 && remain_reg <= count_reg))
        else $error("rotation step count out of range");

    // an append into a non-full list grows the count by one
    a_append_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_action == okl_pkg::ACT_APPEND && count_reg != CNT_W'(DEPTH))
            |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not grow the list");

    // a list never changes the key count
    a_list_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |=> (count_reg == $past(count_reg)))
        else $error("list changed the key count");
`endif

endmodule
